@@ design/tksd_pkg.sv @@
// shared types and constants for the terminal key sequence decoder
package tksd_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_ESC  = 3'b010,
    MODE_SEQ  = 3'b100
  } mode_e;

  localparam logic [7:0] ChrEsc    = 8'h1B;
  localparam logic [7:0] ChrCr     = 8'h0D;
  localparam logic [7:0] ChrLf     = 8'h0A;
  localparam logic [7:0] ChrDel    = 8'h7F;
  localparam logic [7:0] ChrBs     = 8'h08;
  localparam logic [7:0] ChrCsi    = 8'h5B;
  localparam logic [7:0] ChrSs3    = 8'h4F;
  localparam logic [7:0] ChrTilde  = 8'h7E;
  localparam logic [7:0] FinalLow  = 8'h40;
  localparam logic [7:0] FinalHigh = 8'h7E;

  // final bytes of a sequence
  localparam logic [7:0] FinUp    = 8'h41;
  localparam logic [7:0] FinDown  = 8'h42;
  localparam logic [7:0] FinRight = 8'h43;
  localparam logic [7:0] FinLeft  = 8'h44;
  localparam logic [7:0] FinEnd   = 8'h46;
  localparam logic [7:0] FinHome  = 8'h48;

  // parameter digits used with the tilde final byte
  localparam logic [7:0] ParZero = 8'h30;
  localparam logic [7:0] Par1    = 8'h31;
  localparam logic [7:0] Par2    = 8'h32;
  localparam logic [7:0] Par3    = 8'h33;
  localparam logic [7:0] Par4    = 8'h34;
  localparam logic [7:0] Par5    = 8'h35;
  localparam logic [7:0] Par6    = 8'h36;
  localparam logic [7:0] Par7    = 8'h37;
  localparam logic [7:0] Par8    = 8'h38;

  localparam logic [8:0] KeyUp        = 9'h100;
  localparam logic [8:0] KeyDown      = 9'h101;
  localparam logic [8:0] KeyLeft      = 9'h102;
  localparam logic [8:0] KeyRight     = 9'h103;
  localparam logic [8:0] KeyHome      = 9'h104;
  localparam logic [8:0] KeyEnd       = 9'h105;
  localparam logic [8:0] KeyPgUp      = 9'h106;
  localparam logic [8:0] KeyPgDn      = 9'h107;
  localparam logic [8:0] KeyDelete    = 9'h108;
  localparam logic [8:0] KeyEnter     = 9'h109;
  localparam logic [8:0] KeyBackspace = 9'h10A;

endpackage

@@ design/terminal_key_sequence_decoder.sv @@
// terminal key sequence decoder: bytes in, logical key codes out
//
// s_axis carries received terminal bytes, one per beat, in tdata[7:0].
// m_axis carries decoded keys: tdata[8:0] is the key code (0..255 plain
// byte, 256 and up for arrows, home, end, page keys, delete, enter and
// backspace), tuser is set when an escape sequence was not recognized,
// with the key code then zero.
// ESC when idle, the '[' or 'O' after it and parameter bytes give no output beat;
// every other input byte gives exactly one.
// An output beat appears in the cycle after its input beat is accepted. One byte is taken
// every cycle: the decode is a single level of logic between the sequence
// state registers and one output register, and the input is ready whenever
// that register is empty or being drained in the same cycle.
// When the receiver stalls with a key pending, input is held off until the
// pending key is taken.
// Reset clears the sequence state to idle and drops any pending output.
// PARAM_BUFFER_BYTES sets how many parameter bytes are counted (one less
// than it, at most seven); only a single kept byte decodes with '~'.
module terminal_key_sequence_decoder #(
  parameter int PARAM_BUFFER_BYTES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] rx_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // [8:0] key_code, [15:9] zero
  output logic       m_axis_tuser_o    // [0] key_error
);

  localparam int KeepInt = (PARAM_BUFFER_BYTES - 1 > 7) ? 7 :
                           ((PARAM_BUFFER_BYTES - 1 < 0) ? 0 : PARAM_BUFFER_BYTES - 1);
  localparam logic [2:0] KeepLimit = 3'(KeepInt);

  tksd_pkg::mode_e mode_q, mode_d;
  logic [7:0] first_q, first_d;
  logic [2:0] cnt_q, cnt_d;

  logic       out_valid_q;
  logic [8:0] code_q;
  logic       err_q;

  logic       res_valid;
  logic [8:0] res_code;
  logic       res_err;
  logic       accept;
  logic [7:0] rx;

  assign rx              = s_axis_tdata_i;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    mode_d    = mode_q;
    first_d   = first_q;
    cnt_d     = cnt_q;
    res_valid = 1'b0;
    res_code  = '0;
    res_err   = 1'b0;
    unique case (mode_q)
      tksd_pkg::MODE_ESC: begin
        if (rx == tksd_pkg::ChrCsi || rx == tksd_pkg::ChrSs3) begin
          mode_d  = tksd_pkg::MODE_SEQ;
          cnt_d   = '0;
          first_d = '0;
        end else begin
          mode_d    = tksd_pkg::MODE_IDLE;
          res_valid = 1'b1;
          res_err   = 1'b1;
        end
      end
      tksd_pkg::MODE_SEQ: begin
        if (rx >= tksd_pkg::FinalLow && rx <= tksd_pkg::FinalHigh) begin
          mode_d    = tksd_pkg::MODE_IDLE;
          res_valid = 1'b1;
          res_err   = 1'b1;
          unique case (rx)
            tksd_pkg::FinUp: begin
              res_code = tksd_pkg::KeyUp;
              res_err  = 1'b0;
            end
            tksd_pkg::FinDown: begin
              res_code = tksd_pkg::KeyDown;
              res_err  = 1'b0;
            end
            tksd_pkg::FinRight: begin
              res_code = tksd_pkg::KeyRight;
              res_err  = 1'b0;
            end
            tksd_pkg::FinLeft: begin
              res_code = tksd_pkg::KeyLeft;
              res_err  = 1'b0;
            end
            tksd_pkg::FinHome: begin
              res_code = tksd_pkg::KeyHome;
              res_err  = 1'b0;
            end
            tksd_pkg::FinEnd: begin
              res_code = tksd_pkg::KeyEnd;
              res_err  = 1'b0;
            end
            tksd_pkg::ChrTilde: begin
              if (cnt_q == 3'd1) begin
                res_err = 1'b0;
                unique case (first_q) inside
                  tksd_pkg::Par3:                 res_code = tksd_pkg::KeyDelete;
                  tksd_pkg::Par1, tksd_pkg::Par7: res_code = tksd_pkg::KeyHome;
                  tksd_pkg::Par4, tksd_pkg::Par8: res_code = tksd_pkg::KeyEnd;
                  tksd_pkg::Par5:                 res_code = tksd_pkg::KeyPgUp;
                  tksd_pkg::Par6:                 res_code = tksd_pkg::KeyPgDn;
                  default:                        res_err  = 1'b1;
                endcase
              end
            end
            default: res_err = 1'b1;
          endcase
        end else if (cnt_q < KeepLimit) begin
          // only the first parameter byte is kept, the rest are counted
          if (cnt_q == 3'd0) begin
            first_d = rx;
          end
          cnt_d = cnt_q + 3'd1;
        end
      end
      default: begin
        mode_d = tksd_pkg::MODE_IDLE;
        if (rx == tksd_pkg::ChrEsc) begin
          mode_d = tksd_pkg::MODE_ESC;
        end else begin
          res_valid = 1'b1;
          if (rx == tksd_pkg::ChrCr || rx == tksd_pkg::ChrLf) begin
            res_code = tksd_pkg::KeyEnter;
          end else if (rx == tksd_pkg::ChrDel || rx == tksd_pkg::ChrBs) begin
            res_code = tksd_pkg::KeyBackspace;
          end else begin
            res_code = {1'b0, rx};
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= tksd_pkg::MODE_IDLE;
      first_q <= '0;
      cnt_q   <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      first_q <= first_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      code_q <= res_code;
      err_q  <= res_err;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, code_q};
  assign m_axis_tuser_o  = err_q;

endmodule

@@ tb/sv/tb_top.sv @@
// self-checking testbench for the terminal key sequence decoder
`timescale 1ns / 100ps

module tb_top;

  localparam int ParamBufferBytes = 8;
  localparam int KeepLimit = (ParamBufferBytes - 1 > 7) ? 7 : ParamBufferBytes - 1;
  localparam int MaxCycles = 200000;
  localparam int TargetBytes = 750;
  localparam int QuietFrom = 650;
  localparam int DrainEvery = 200;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic [8:0] code;
    logic       err;
  } key_t;

  class key_scoreboard;
    tksd_pkg::mode_e mode;
    logic [7:0]  first_param;
    int unsigned kept;
    key_t        pending_keys[$];
    int          mismatches;
    int          keys_checked;
    int          error_keys;

    function new();
      mode = tksd_pkg::MODE_IDLE;
      first_param = '0;
      kept = 0;
      mismatches = 0;
      keys_checked = 0;
      error_keys = 0;
    endfunction

    function logic [8:0] final_key(input logic [7:0] fin, output logic err);
      err = 1'b0;
      unique case (fin)
        tksd_pkg::FinUp:    return tksd_pkg::KeyUp;
        tksd_pkg::FinDown:  return tksd_pkg::KeyDown;
        tksd_pkg::FinRight: return tksd_pkg::KeyRight;
        tksd_pkg::FinLeft:  return tksd_pkg::KeyLeft;
        tksd_pkg::FinHome:  return tksd_pkg::KeyHome;
        tksd_pkg::FinEnd:   return tksd_pkg::KeyEnd;
        tksd_pkg::ChrTilde: begin
          if (kept == 1) begin
            unique case (first_param) inside
              tksd_pkg::Par3:                 return tksd_pkg::KeyDelete;
              tksd_pkg::Par1, tksd_pkg::Par7: return tksd_pkg::KeyHome;
              tksd_pkg::Par4, tksd_pkg::Par8: return tksd_pkg::KeyEnd;
              tksd_pkg::Par5:                 return tksd_pkg::KeyPgUp;
              tksd_pkg::Par6:                 return tksd_pkg::KeyPgDn;
              default: ;
            endcase
          end
        end
        default: ;
      endcase
      err = 1'b1;
      return '0;
    endfunction

    // advance the decode state by one accepted byte
    function void note_byte(input logic [7:0] b);
      key_t k;
      logic hit;
      logic e;
      k = '0;
      hit = 1'b0;
      unique case (mode)
        tksd_pkg::MODE_ESC: begin
          if (b == tksd_pkg::ChrCsi || b == tksd_pkg::ChrSs3) begin
            mode = tksd_pkg::MODE_SEQ;
            kept = 0;
            first_param = '0;
          end else begin
            mode = tksd_pkg::MODE_IDLE;
            k.err = 1'b1;
            hit = 1'b1;
          end
        end
        tksd_pkg::MODE_SEQ: begin
          if (b >= tksd_pkg::FinalLow && b <= tksd_pkg::FinalHigh) begin
            k.code = final_key(b, e);
            k.err = e;
            mode = tksd_pkg::MODE_IDLE;
            hit = 1'b1;
          end else if (kept < KeepLimit) begin
            if (kept == 0) first_param = b;
            kept++;
          end
        end
        default: begin
          mode = tksd_pkg::MODE_IDLE;
          if (b == tksd_pkg::ChrEsc) begin
            mode = tksd_pkg::MODE_ESC;
          end else begin
            hit = 1'b1;
            if (b == tksd_pkg::ChrCr || b == tksd_pkg::ChrLf) k.code = tksd_pkg::KeyEnter;
            else if (b == tksd_pkg::ChrDel || b == tksd_pkg::ChrBs) begin
              k.code = tksd_pkg::KeyBackspace;
            end
            else k.code = {1'b0, b};
          end
        end
      endcase
      if (hit) pending_keys.push_back(k);
    endfunction

    function void flag(input string msg);
      mismatches++;
      if (mismatches <= MaxReports) $display("%0t: %s", $time, msg);
    endfunction

    function void check_key(input logic [15:0] data, input logic err);
      key_t want;
      keys_checked++;
      if (pending_keys.size() == 0) begin
        flag($sformatf("key beat with nothing pending: data %h err %b", data, err));
        return;
      end
      want = pending_keys.pop_front();
      if (want.err) error_keys++;
      if (data[8:0] !== want.code || data[15:9] !== 7'd0 || err !== want.err)
        flag($sformatf("key %0d: expected code %h err %b, got data %h err %b",
                       keys_checked, want.code, want.err, data, err));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        tx_valid = 1'b0;
  logic [7:0]  tx_data = '0;
  logic        rx_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  key_scoreboard board = new();
  logic [7:0]  seq_q[$];
  int          bytes_sent = 0;
  int          seqs_sent = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;
  bit          tx_calm = 1'b0;

  terminal_key_sequence_decoder #(
    .PARAM_BUFFER_BYTES(ParamBufferBytes)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(tx_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (tx_data),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(rx_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= MaxCycles) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // key sink: check on handshake, then pick the next ready value
  int rx_stall_left = 0;
  int rx_calm_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && rx_ready) board.check_key(m_axis_tdata_o, m_axis_tuser_o);
    if (rx_calm_left > 0) rx_calm_left--;
    if (rx_stall_left > 0) begin
      rx_ready <= 1'b0;
      rx_stall_left--;
    end else if (!quiet && rx_calm_left == 0 && $urandom_range(0, 4) == 0) begin
      rx_ready <= 1'b0;
      rx_stall_left = $urandom_range(0, 3);
    end else begin
      rx_ready <= 1'b1;
      if ($urandom_range(0, 30) == 0) rx_calm_left = $urandom_range(10, 40);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (!quiet && !tx_calm && $urandom_range(0, 3) == 0) begin
      tx_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    tx_valid <= 1'b1;
    tx_data <= b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    board.note_byte(b);
    bytes_sent++;
  endtask

  task automatic flush_seq();
    foreach (seq_q[i]) send_byte(seq_q[i]);
    seq_q.delete();
    seqs_sent++;
  endtask

  // hold off input until every pending key has been taken
  task automatic drain_keys();
    tx_valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending_keys.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] noise_param();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 8'h3F));
    return 8'($urandom_range(8'h7F, 8'hFF));
  endfunction

  function automatic logic [7:0] pick_final();
    logic [7:0] finals[9];
    finals = '{tksd_pkg::FinUp, tksd_pkg::FinDown, tksd_pkg::FinRight,
               tksd_pkg::FinLeft, tksd_pkg::FinHome, tksd_pkg::FinEnd,
               tksd_pkg::ChrTilde, tksd_pkg::ChrTilde, tksd_pkg::ChrTilde};
    if ($urandom_range(0, 5) == 0) begin
      return 8'($urandom_range(tksd_pkg::FinalLow, tksd_pkg::FinalHigh));
    end
    return finals[$urandom_range(0, 8)];
  endfunction

  task automatic directed_traffic();
    logic [7:0] tilde_params[8];
    tilde_params = '{tksd_pkg::Par3, tksd_pkg::Par1, tksd_pkg::Par7, tksd_pkg::Par4,
                     tksd_pkg::Par8, tksd_pkg::Par5, tksd_pkg::Par6, tksd_pkg::Par2};
    seq_q = {8'h00, 8'hFF, tksd_pkg::ChrCr, tksd_pkg::ChrLf, tksd_pkg::ChrDel,
             tksd_pkg::ChrBs, tksd_pkg::ChrTilde, tksd_pkg::FinalLow, 8'h61};
    flush_seq();
    seq_q = {tksd_pkg::ChrEsc, tksd_pkg::FinUp};    // escape not followed by an introducer
    flush_seq();
    seq_q = {tksd_pkg::ChrEsc, tksd_pkg::ChrEsc};
    flush_seq();
    seq_q = {tksd_pkg::ChrEsc, tksd_pkg::ChrCsi, tksd_pkg::FinUp,
             tksd_pkg::ChrEsc, tksd_pkg::ChrSs3, tksd_pkg::FinDown,
             tksd_pkg::ChrEsc, tksd_pkg::ChrCsi, tksd_pkg::FinRight};
    flush_seq();
    seq_q = {tksd_pkg::ChrEsc, tksd_pkg::ChrSs3, tksd_pkg::FinLeft,
             tksd_pkg::ChrEsc, tksd_pkg::ChrCsi, tksd_pkg::FinHome,
             tksd_pkg::ChrEsc, tksd_pkg::ChrSs3, tksd_pkg::FinEnd};
    flush_seq();
    foreach (tilde_params[i]) begin
      seq_q = {tksd_pkg::ChrEsc, tksd_pkg::ChrCsi, tilde_params[i], tksd_pkg::ChrTilde};
      flush_seq();
    end
    // tilde with no parameter
    seq_q = {tksd_pkg::ChrEsc, tksd_pkg::ChrCsi, tksd_pkg::ChrTilde};
    flush_seq();
    // two parameters
    seq_q = {tksd_pkg::ChrEsc, tksd_pkg::ChrCsi, tksd_pkg::Par1, tksd_pkg::Par5,
             tksd_pkg::ChrTilde};
    flush_seq();
    seq_q = {tksd_pkg::ChrEsc, tksd_pkg::ChrCsi, tksd_pkg::Par5, tksd_pkg::FinUp,
             tksd_pkg::ChrEsc, tksd_pkg::ChrCsi, tksd_pkg::FinalLow};
    flush_seq();
    seq_q = {tksd_pkg::ChrEsc, tksd_pkg::ChrCsi, 8'h00, tksd_pkg::ChrTilde,
             tksd_pkg::ChrEsc, tksd_pkg::ChrCsi, tksd_pkg::ChrEsc, tksd_pkg::ChrTilde};
    flush_seq();
    // parameter overflow, count saturates
    seq_q = {tksd_pkg::ChrEsc, tksd_pkg::ChrCsi, tksd_pkg::Par3};
    repeat (11) seq_q.push_back(noise_param());
    seq_q.push_back(tksd_pkg::ChrTilde);
    seq_q.push_back(tksd_pkg::ChrEsc);
    seq_q.push_back(tksd_pkg::ChrSs3);
    repeat (9) seq_q.push_back(8'hFF);
    seq_q.push_back(tksd_pkg::FinHome);
    flush_seq();
  endtask

  task automatic random_traffic();
    int unsigned pick;
    int          nparam;
    int          next_drain;
    next_drain = bytes_sent + DrainEvery;
    while (bytes_sent < TargetBytes) begin
      quiet = (bytes_sent >= QuietFrom);
      tx_calm = ($urandom_range(0, 4) == 0);
      if (bytes_sent >= next_drain) begin
        drain_keys();
        next_drain += DrainEvery;
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        seq_q = {8'($urandom_range(0, 255))};
      end else if (pick < 85) begin
        seq_q = {tksd_pkg::ChrEsc,
                 ($urandom_range(0, 1) == 0) ? tksd_pkg::ChrCsi : tksd_pkg::ChrSs3};
        pick = $urandom_range(0, 9);
        nparam = (pick == 0) ? 0 : (pick < 8) ? 1 : $urandom_range(2, 3);
        repeat (nparam) begin
          if ($urandom_range(0, 3) != 0) begin
            seq_q.push_back(tksd_pkg::ParZero + 8'($urandom_range(0, 9)));
          end
          else seq_q.push_back(noise_param());
        end
        seq_q.push_back(pick_final());
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            seq_q = {tksd_pkg::ChrEsc, 8'($urandom_range(0, 255))};
          end
          1: begin
            seq_q = {tksd_pkg::ChrEsc, tksd_pkg::ChrCsi};
            repeat ($urandom_range(6, 12)) seq_q.push_back(noise_param());
            seq_q.push_back(pick_final());
          end
          default: begin
            seq_q = {tksd_pkg::ChrEsc, tksd_pkg::ChrSs3, noise_param(),
                     tksd_pkg::ChrEsc, tksd_pkg::ChrEsc};
          end
        endcase
      end
      flush_seq();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_traffic();
    drain_keys();
    random_traffic();
    tx_valid <= 1'b0;
    while (board.pending_keys.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("%0d bytes in %0d sequences, %0d key beats checked, %0d of them error keys",
             bytes_sent, seqs_sent, board.keys_checked, board.error_keys);
    $display("%0d mismatches, %0d keys never delivered",
             board.mismatches, board.pending_keys.size());
    if (board.mismatches == 0 && board.pending_keys.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
